/* rtl/gcdb_pkg.sv */
// gcdb_pkg: widths, fixed-point constants, CORDIC arctangent table and Q30 multiply
// for the great-circle distance and bearing block. No dependencies.
`timescale 1ns / 1ps

package gcdb_pkg;

	// field widths
	localparam int unsigned LAT_W  = 31;
	localparam int unsigned LON_W  = 32;
	localparam int unsigned DIST_W = 25;
	localparam int unsigned BEAR_W = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned CORDIC_STAGES_DEF = 24;

	// internal widths
	localparam int unsigned AW  = 35;	// Q30 angle before reduction
	localparam int unsigned ZW  = 33;	// rotation residual angle
	localparam int unsigned XW  = 34;	// rotation x/y
	localparam int unsigned TW  = 32;	// Q30 trig values and products
	localparam int unsigned VW  = 36;	// vectoring x/y
	localparam int unsigned VZ  = 34;	// vectoring angle accumulator
	localparam int unsigned SQW = 62;	// square root working width

	localparam logic signed [AW-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [AW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_INV_Q30 = 34'sd652032874;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam int unsigned EARTH_RADIUS_KM = 6371;
	localparam logic signed [23:0] EARTH_M = 24'(EARTH_RADIUS_KM * 1000);
	localparam logic [DIST_W-1:0] DIST_MAX = 25'd20015087;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEST_LAT = 2'd0,
		CFG_DEST_LON = 2'd1,
		CFG_NAV_EN   = 2'd2
	} cfg_reg_t;

	// atan(2^-i) in Q30
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// Q30 x Q30, floor shift; magnitudes stay near one so TW bits suffice
	function automatic logic signed [TW-1:0] qmul(input logic signed [TW-1:0] a,
			input logic signed [TW-1:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[61:30];
	endfunction

endpackage

/* rtl/gcdb_pos_if.sv */
// gcdb_pos_if: valid/ready channel carrying one position item.
// Depends on gcdb_pkg for field widths.
`timescale 1ns / 1ps

interface gcdb_pos_if import gcdb_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [LAT_W-1:0] cur_latitude;
	logic signed [LON_W-1:0] cur_longitude;

	modport source (output valid, cur_latitude, cur_longitude, input ready);
	modport sink   (input valid, cur_latitude, cur_longitude, output ready);
endinterface

/* rtl/gcdb_res_if.sv */
// gcdb_res_if: valid/ready channel carrying one distance/bearing item.
// Depends on gcdb_pkg for field widths.
`timescale 1ns / 1ps

interface gcdb_res_if import gcdb_pkg::*; ();
	logic valid;
	logic ready;
	logic [DIST_W-1:0] distance_m;
	logic signed [BEAR_W-1:0] bearing;

	modport source (output valid, distance_m, bearing, input ready);
	modport sink   (input valid, distance_m, bearing, output ready);
endinterface

/* rtl/great_circle_distance_bearing.sv */
// channel     dir  payload                                   accepted when
// position    in   cur_latitude[31] s, cur_longitude[32] s   valid & ready
// result      out  distance_m[25] u, bearing[32] s           valid & ready
// cfg         in   cfg_index[2], cfg_wdata[32]               cfg_we
//
// One item per cycle sustained while the skid register is empty. Each item passes through
// the rotation CORDIC, the 31-step square root and the vectoring CORDIC, each one
// register stage per step.
// arst_n clears the valid bits, the output/skid flags and the configuration.
// A stalled result sits in the output register; one more item lands in the skid
// register, and position.ready drops (a registered flag) until the skid drains.
//
// Top level: haversine distance and initial bearing to a configured waypoint.
// Depends on gcdb_pkg, gcdb_pos_if, gcdb_res_if.
`timescale 1ns / 1ps

module great_circle_distance_bearing import gcdb_pkg::*; #(
	parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gcdb_pos_if.sink              position,
	gcdb_res_if.source            result
);

	localparam int unsigned N     = CORDIC_STAGES;
	localparam int unsigned NROT  = 5;	// lat1*2, lat2*2, dlat, dlon, dlon*2
	localparam int unsigned SQN   = 31;	// one root bit per step
	localparam int unsigned LAT   = 42 + 2 * N;

	// ---------------- configuration ----------------
	logic signed [LAT_W-1:0] dest_lat_q;
	logic signed [LON_W-1:0] dest_lon_q;
	logic                    nav_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_lat_q <= '0;
			dest_lon_q <= '0;
			nav_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DEST_LAT: dest_lat_q <= cfg_wdata[LAT_W-1:0];
				CFG_DEST_LON: dest_lon_q <= cfg_wdata[LON_W-1:0];
				CFG_NAV_EN:   nav_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	logic           skid_vld_q;
	logic           out_vld_q;
	logic           en;
	logic           in_acc;
	logic [LAT-1:0] vld_q;

	assign en             = !skid_vld_q;
	assign position.ready = en;
	assign in_acc         = position.valid && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_acc};
	end

	// ---------------- angle set-up and range reduction ----------------
	logic signed [AW-1:0] ang_s1 [NROT];
	logic signed [AW-1:0] ang_s2 [NROT];
	logic signed [AW-1:0] ang_s3 [NROT];

	always_ff @(posedge clk) begin
		if (en) begin
			// a Q29 angle read as Q30 is half of it
			ang_s1[0] <= AW'(position.cur_latitude) <<< 1;
			ang_s1[1] <= AW'(dest_lat_q) <<< 1;
			ang_s1[2] <= AW'(dest_lat_q) - AW'(position.cur_latitude);
			ang_s1[3] <= AW'(dest_lon_q) - AW'(position.cur_longitude);
			ang_s1[4] <= (AW'(dest_lon_q) - AW'(position.cur_longitude)) <<< 1;
			for (int l = 0; l < NROT; l++) begin
				// truncating remainder by 2pi; one step covers the input span
				if (ang_s1[l] >= TWO_PI_Q30)
					ang_s2[l] <= ang_s1[l] - TWO_PI_Q30;
				else if (ang_s1[l] <= -TWO_PI_Q30)
					ang_s2[l] <= ang_s1[l] + TWO_PI_Q30;
				else
					ang_s2[l] <= ang_s1[l];
				if (ang_s2[l] > PI_Q30)
					ang_s3[l] <= ang_s2[l] - TWO_PI_Q30;
				else if (ang_s2[l] < -PI_Q30)
					ang_s3[l] <= ang_s2[l] + TWO_PI_Q30;
				else
					ang_s3[l] <= ang_s2[l];
			end
		end
	end

	// ---------------- rotation CORDIC, five lanes ----------------
	logic signed [XW-1:0] rot_x_s [NROT][N+1];
	logic signed [XW-1:0] rot_y_s [NROT][N+1];
	logic signed [ZW-1:0] rot_z_s [NROT][N+1];
	logic [NROT-1:0]      rot_neg_s [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NROT; l++) begin
				rot_x_s[l][0] <= GAIN_INV_Q30;
				rot_y_s[l][0] <= '0;
				// fold into [-pi/2, pi/2], negate sine and cosine afterwards
				if (ang_s3[l] > HALF_PI_Q30) begin
					rot_z_s[l][0]   <= ZW'(ang_s3[l] - PI_Q30);
					rot_neg_s[0][l] <= 1'b1;
				end else if (ang_s3[l] < -HALF_PI_Q30) begin
					rot_z_s[l][0]   <= ZW'(ang_s3[l] + PI_Q30);
					rot_neg_s[0][l] <= 1'b1;
				end else begin
					rot_z_s[l][0]   <= ZW'(ang_s3[l]);
					rot_neg_s[0][l] <= 1'b0;
				end
				for (int i = 0; i < N; i++) begin
					if (rot_z_s[l][i] >= 0) begin
						rot_x_s[l][i+1] <= rot_x_s[l][i] - (rot_y_s[l][i] >>> i);
						rot_y_s[l][i+1] <= rot_y_s[l][i] + (rot_x_s[l][i] >>> i);
						rot_z_s[l][i+1] <= rot_z_s[l][i] - $signed(ZW'(ATAN_TAB[i[4:0]]));
					end else begin
						rot_x_s[l][i+1] <= rot_x_s[l][i] + (rot_y_s[l][i] >>> i);
						rot_y_s[l][i+1] <= rot_y_s[l][i] - (rot_x_s[l][i] >>> i);
						rot_z_s[l][i+1] <= rot_z_s[l][i] + $signed(ZW'(ATAN_TAB[i[4:0]]));
					end
				end
			end
			for (int i = 0; i < N; i++)
				rot_neg_s[i+1] <= rot_neg_s[i];
		end
	end

	// ---------------- trig values and products ----------------
	logic signed [TW-1:0] s1_t, c1_t, s2_t, c2_t, shl_t, shn_t, sn_t, cn_t;
	logic signed [TW-1:0] shl2_m1, c12_m1, shn2_m1, s1c2_m1, by_m1, c1s2_m1, cn_m1;
	logic signed [TW-1:0] shl2_m2, hav_m2, s1c2cn_m2, by_m2, c1s2_m2;
	logic [30:0]          a_m3;
	logic signed [TW:0]   bx_m3;
	logic signed [TW-1:0] by_m3;
	logic signed [TW:0]   asum;

	always_ff @(posedge clk) begin
		if (en) begin
			s1_t  <= TW'(rot_neg_s[N][0] ? -rot_y_s[0][N] : rot_y_s[0][N]);
			c1_t  <= TW'(rot_neg_s[N][0] ? -rot_x_s[0][N] : rot_x_s[0][N]);
			s2_t  <= TW'(rot_neg_s[N][1] ? -rot_y_s[1][N] : rot_y_s[1][N]);
			c2_t  <= TW'(rot_neg_s[N][1] ? -rot_x_s[1][N] : rot_x_s[1][N]);
			shl_t <= TW'(rot_neg_s[N][2] ? -rot_y_s[2][N] : rot_y_s[2][N]);
			shn_t <= TW'(rot_neg_s[N][3] ? -rot_y_s[3][N] : rot_y_s[3][N]);
			sn_t  <= TW'(rot_neg_s[N][4] ? -rot_y_s[4][N] : rot_y_s[4][N]);
			cn_t  <= TW'(rot_neg_s[N][4] ? -rot_x_s[4][N] : rot_x_s[4][N]);

			shl2_m1 <= qmul(shl_t, shl_t);
			c12_m1  <= qmul(c1_t, c2_t);
			shn2_m1 <= qmul(shn_t, shn_t);
			s1c2_m1 <= qmul(s1_t, c2_t);
			by_m1   <= qmul(sn_t, c2_t);
			c1s2_m1 <= qmul(c1_t, s2_t);
			cn_m1   <= cn_t;

			shl2_m2   <= shl2_m1;
			hav_m2    <= qmul(c12_m1, shn2_m1);
			s1c2cn_m2 <= qmul(s1c2_m1, cn_m1);
			by_m2     <= by_m1;
			c1s2_m2   <= c1s2_m1;

			// haversine term clamped to [0, 1]
			if (asum < 0)
				a_m3 <= '0;
			else if (asum > $signed({2'b00, ONE_Q30}))
				a_m3 <= ONE_Q30;
			else
				a_m3 <= asum[30:0];
			bx_m3 <= (TW+1)'(c1s2_m2) - (TW+1)'(s1c2cn_m2);
			by_m3 <= by_m2;
		end
	end

	assign asum = (TW+1)'(shl2_m2) + (TW+1)'(hav_m2);

	// ---------------- square roots of a and 1-a, one bit per stage ----------------
	logic [SQW-1:0]       sq_v_s [2][SQN+1];
	logic [SQW-1:0]       sq_r_s [2][SQN+1];
	logic signed [TW-1:0] sq_by_s [SQN+1];
	logic signed [TW:0]   sq_bx_s [SQN+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0][0] <= {1'b0, a_m3, 30'b0};
			sq_v_s[1][0] <= {1'b0, ONE_Q30 - a_m3, 30'b0};
			sq_r_s[0][0] <= '0;
			sq_r_s[1][0] <= '0;
			sq_by_s[0]   <= by_m3;
			sq_bx_s[0]   <= bx_m3;
			for (int l = 0; l < 2; l++) begin
				for (int k = 0; k < SQN; k++) begin
					if (sq_v_s[l][k] >= sq_r_s[l][k] + (SQW'(1) << (60 - 2 * k))) begin
						sq_v_s[l][k+1] <= sq_v_s[l][k] - sq_r_s[l][k]
							- (SQW'(1) << (60 - 2 * k));
						sq_r_s[l][k+1] <= (sq_r_s[l][k] >> 1) + (SQW'(1) << (60 - 2 * k));
					end else begin
						sq_v_s[l][k+1] <= sq_v_s[l][k];
						sq_r_s[l][k+1] <= sq_r_s[l][k] >> 1;
					end
				end
			end
			for (int k = 0; k < SQN; k++) begin
				sq_by_s[k+1] <= sq_by_s[k];
				sq_bx_s[k+1] <= sq_bx_s[k];
			end
		end
	end

	// ---------------- vectoring CORDIC: lane 0 distance, lane 1 bearing ----------------
	logic signed [VW-1:0] vin_x [2];
	logic signed [VW-1:0] vin_y [2];
	logic signed [VW-1:0] vec_x_s [2][N+1];
	logic signed [VW-1:0] vec_y_s [2][N+1];
	logic signed [VZ-1:0] vec_z_s [2][N+1];
	logic [1:0]           vec_zero_s [N+1];

	always_comb begin
		vin_x[0] = $signed(VW'(sq_r_s[1][SQN][30:0]));	// sqrt(1-a)
		vin_y[0] = $signed(VW'(sq_r_s[0][SQN][30:0]));	// sqrt(a)
		vin_x[1] = VW'(sq_bx_s[SQN]);
		vin_y[1] = VW'(sq_by_s[SQN]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				vec_zero_s[0][l] <= (vin_x[l] == 0) && (vin_y[l] == 0);
				// left half plane: turn by a quarter first
				if (vin_x[l] < 0) begin
					if (vin_y[l] >= 0) begin
						vec_x_s[l][0] <= vin_y[l];
						vec_y_s[l][0] <= -vin_x[l];
						vec_z_s[l][0] <= VZ'(HALF_PI_Q30);
					end else begin
						vec_x_s[l][0] <= -vin_y[l];
						vec_y_s[l][0] <= vin_x[l];
						vec_z_s[l][0] <= VZ'(-HALF_PI_Q30);
					end
				end else begin
					vec_x_s[l][0] <= vin_x[l];
					vec_y_s[l][0] <= vin_y[l];
					vec_z_s[l][0] <= '0;
				end
				for (int i = 0; i < N; i++) begin
					if (vec_y_s[l][i] > 0) begin
						vec_x_s[l][i+1] <= vec_x_s[l][i] + (vec_y_s[l][i] >>> i);
						vec_y_s[l][i+1] <= vec_y_s[l][i] - (vec_x_s[l][i] >>> i);
						vec_z_s[l][i+1] <= vec_z_s[l][i] + $signed(VZ'(ATAN_TAB[i[4:0]]));
					end else begin
						vec_x_s[l][i+1] <= vec_x_s[l][i] - (vec_y_s[l][i] >>> i);
						vec_y_s[l][i+1] <= vec_y_s[l][i] + (vec_x_s[l][i] >>> i);
						vec_z_s[l][i+1] <= vec_z_s[l][i] - $signed(VZ'(ATAN_TAB[i[4:0]]));
					end
				end
			end
			for (int i = 0; i < N; i++)
				vec_zero_s[i+1] <= vec_zero_s[i];
		end
	end

	// ---------------- scaling ----------------
	logic signed [VZ-1:0]     zd, zb;
	logic signed [VZ:0]       cang;
	logic signed [59:0]       dprod;
	logic signed [VZ:0]       bsum;
	logic signed [29:0]       dist_f1;
	logic signed [BEAR_W-1:0] bear_f1;

	always_comb begin
		zd    = vec_zero_s[N][0] ? '0 : vec_z_s[0][N];
		zb    = vec_zero_s[N][1] ? '0 : vec_z_s[1][N];
		cang  = (VZ+1)'(zd) <<< 1;	// central angle = 2 * atan2
		dprod = 60'(cang) * 60'(EARTH_M) + 60'sd536870912;
		bsum  = (VZ+1)'(zb) + (VZ+1)'(1);	// Q30 to Q29, round half up
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_f1 <= dprod[59:30];
			bear_f1 <= bsum[BEAR_W:1];
		end
	end

	// ---------------- saturation, enable gating, output and skid ----------------
	logic [DIST_W-1:0]        pipe_dist;
	logic signed [BEAR_W-1:0] pipe_bear;
	logic                     pipe_vld;
	logic                     out_take;
	logic [DIST_W-1:0]        out_dist_q, skid_dist_q;
	logic signed [BEAR_W-1:0] out_bear_q, skid_bear_q;

	always_comb begin
		if (!nav_q)
			pipe_dist = '0;
		else if (dist_f1 > $signed(30'(DIST_MAX)))
			pipe_dist = DIST_MAX;
		else if (dist_f1 < 0)
			pipe_dist = '0;
		else
			pipe_dist = dist_f1[DIST_W-1:0];
		pipe_bear = nav_q ? bear_f1 : '0;
	end

	assign pipe_vld = vld_q[LAT-1] && en;
	assign out_take = out_vld_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pipe_vld) begin
			if (!out_vld_q || result.ready)
				out_vld_q <= 1'b1;
			else
				skid_vld_q <= 1'b1;
		end else if (out_take) begin
			if (skid_vld_q)
				skid_vld_q <= 1'b0;
			else
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_vld) begin
			if (!out_vld_q || result.ready) begin
				out_dist_q <= pipe_dist;
				out_bear_q <= pipe_bear;
			end else begin
				skid_dist_q <= pipe_dist;
				skid_bear_q <= pipe_bear;
			end
		end else if (out_take && skid_vld_q) begin
			out_dist_q <= skid_dist_q;
			out_bear_q <= skid_bear_q;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.distance_m = out_dist_q;
	assign result.bearing    = out_bear_q;

endmodule

/* rtl/gcdb_checker.sv */
// gcdb_checker: port-level assertions for great_circle_distance_bearing, and its bind.
// Depends on gcdb_pkg.
`timescale 1ns / 1ps

module gcdb_checker import gcdb_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic [DIST_W-1:0]        distance_m,
	input logic signed [BEAR_W-1:0] bearing
);

	logic [7:0] pend_q;	// items taken, result not yet delivered

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance_m) && $stable(bearing))
		else $error("result changed while stalled");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_m <= DIST_MAX)
		else $error("distance above half circumference");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result without an item in flight");

endmodule

bind great_circle_distance_bearing gcdb_checker u_gcdb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (position.valid),
	.in_ready   (position.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.distance_m (result.distance_m),
	.bearing    (result.bearing)
);
